@@ rtl/ple_pkg.sv @@
// Shared types and constants for the positional list engine.
package ple_pkg;

    localparam int DEPTH_DEFAULT       = 64;
    localparam int VALUE_WIDTH_DEFAULT = 16;

    localparam int OP_W    = 3;
    localparam int POS_W   = 7;
    localparam int VAL_W   = 16;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 7;

    typedef enum logic [OP_W-1:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_BACK  = 3'd1,
        OP_INS_AT    = 3'd2,
        OP_REM_FRONT = 3'd3,
        OP_REM_BACK  = 3'd4,
        OP_REM_AT    = 3'd5
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    // Per-cycle command broadcast to every cell.
    typedef struct packed {
        logic ins;
        logic rem;
    } cell_ctl_t;

endpackage

@@ rtl/ple_cell.sv @@
// One list slot: holds an entry and shifts with its neighbors.
module ple_cell #(
    parameter int IDX   = 0,
    parameter int VW    = 16,
    parameter int PW    = 7
) (
    input  logic                  aclk,
    input  ple_pkg::cell_ctl_t    ctl,
    input  logic [PW-1:0]         pos,
    input  logic [VW-1:0]         ins_value,
    input  logic [VW-1:0]         left_data,
    input  logic [VW-1:0]         right_data,
    output logic [VW-1:0]         data,
    output logic [VW-1:0]         tap
);
    import ple_pkg::*;

    localparam logic [PW-1:0] MY_IDX = PW'(IDX);

    logic [VW-1:0] data_reg;
    logic [VW-1:0] data_next;

    always_comb begin
        data_next = data_reg;
        if (ctl.ins) begin
            if (MY_IDX == pos) begin
                data_next = ins_value;
            end else if (MY_IDX > pos) begin
                data_next = left_data;
            end
        end else if (ctl.rem) begin
            if (MY_IDX >= pos) begin
                data_next = right_data;
            end
        end
    end

    // payload only, no reset
    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;
    assign tap  = (MY_IDX == pos) ? data_reg : '0;

endmodule

@@ rtl/positional_list_engine.sv @@
// Top level: ordered list with positional insert and remove.
//
// Input channel s_*: one word per operation (op, position, value).
// Result channel m_*: one word per operation (status, removed value,
// entry count after the operation), in input order.
// Every accepted word updates the list in the cycle it is accepted; the
// result appears on m_* in the next cycle and sits in an output register.
// Throughput is one word per cycle while m_ready is high: the row of cells
// shifts all entries at once, so the only limit is the output register,
// which takes a new result in the same cycle the old one is taken.
// If the receiver stalls (m_ready low with m_valid high), s_ready drops
// until the pending result is taken; nothing is lost.
// Reset (aresetn low, synchronous) empties the list and clears m_valid.
// Entry contents are not reset; only entries below the count are read.
// Errors (bad position, empty, full) leave the list unchanged and return
// a removed value of zero. Unused op codes return ok and the count.
module positional_list_engine #(
    parameter int DEPTH       = ple_pkg::DEPTH_DEFAULT,
    parameter int VALUE_WIDTH = ple_pkg::VALUE_WIDTH_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [ple_pkg::OP_W-1:0]      s_op,
    input  logic [ple_pkg::POS_W-1:0]     s_position,
    input  logic [ple_pkg::VAL_W-1:0]     s_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [ple_pkg::STAT_W-1:0]    m_status,
    output logic [ple_pkg::VAL_W-1:0]     m_removed_value,
    output logic [ple_pkg::COUNT_W-1:0]   m_entry_count
);
    import ple_pkg::*;

    localparam int VW = VALUE_WIDTH;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;
    localparam logic [PW-1:0] DEPTH_P = PW'(DEPTH);

    logic [CW-1:0]      count_reg, count_next;
    logic               m_valid_reg;
    logic [STAT_W-1:0]  status_reg;
    logic [VAL_W-1:0]   removed_reg;
    logic [COUNT_W-1:0] count_out_reg;

    logic               accept;
    logic [PW-1:0]      cnt_p, pos_p, tgt;
    logic               is_ins, is_rem;
    status_t            status;
    cell_ctl_t          ctl;
    logic [VW-1:0]      in_val;
    logic [VW+VAL_W-1:0] in_ext;
    logic [VW-1:0]      rd_val;
    logic [VW+VAL_W-1:0] rd_ext;
    logic [CW+COUNT_W-1:0] cnt_ext;

    logic [VW-1:0] cell_data [DEPTH];
    logic [VW-1:0] cell_tap  [DEPTH];

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign cnt_p  = PW'(count_reg);
    assign pos_p  = PW'(s_position);
    assign in_ext = {{VW{1'b0}}, s_value};
    assign in_val = in_ext[VW-1:0];

    always_comb begin
        is_ins = 1'b0;
        is_rem = 1'b0;
        tgt    = '0;
        status = ST_OK;
        case (s_op)
            OP_INS_FRONT: begin
                is_ins = 1'b1;
                tgt    = '0;
            end
            OP_INS_BACK: begin
                is_ins = 1'b1;
                tgt    = cnt_p;
            end
            OP_INS_AT: begin
                is_ins = 1'b1;
                tgt    = pos_p;
            end
            OP_REM_FRONT: begin
                is_rem = 1'b1;
                tgt    = '0;
            end
            OP_REM_BACK: begin
                is_rem = 1'b1;
                tgt    = cnt_p - PW'(1);
            end
            OP_REM_AT: begin
                is_rem = 1'b1;
                tgt    = pos_p;
            end
            default: begin
                is_ins = 1'b0;
                is_rem = 1'b0;
            end
        endcase
        if (is_ins) begin
            if (pos_p > cnt_p && s_op == OP_INS_AT) begin
                status = ST_RANGE;
            end else if (cnt_p == DEPTH_P) begin
                status = ST_FULL;
            end
        end else if (is_rem) begin
            if (count_reg == '0) begin
                status = ST_EMPTY;
            end else if (pos_p >= cnt_p && s_op == OP_REM_AT) begin
                status = ST_RANGE;
            end
        end
    end

    assign ctl.ins = accept && is_ins && (status == ST_OK);
    assign ctl.rem = accept && is_rem && (status == ST_OK);

    always_comb begin
        count_next = count_reg;
        if (ctl.ins) begin
            count_next = count_reg + CW'(1);
        end else if (ctl.rem) begin
            count_next = count_reg - CW'(1);
        end
    end

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [VW-1:0] left_d, right_d;
        if (i == 0) begin : g_first
            assign left_d = cell_data[i];
        end else begin : g_left
            assign left_d = cell_data[i-1];
        end
        if (i == DEPTH - 1) begin : g_last
            assign right_d = cell_data[i];
        end else begin : g_right
            assign right_d = cell_data[i+1];
        end
        ple_cell #(
            .IDX (i),
            .VW  (VW),
            .PW  (PW)
        ) u_cell (
            .aclk       (aclk),
            .ctl        (ctl),
            .pos        (tgt),
            .ins_value  (in_val),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_data[i]),
            .tap        (cell_tap[i])
        );
    end

    // only the addressed cell drives a nonzero tap
    always_comb begin
        rd_val = '0;
        for (int i = 0; i < DEPTH; i++) begin
            rd_val = rd_val | cell_tap[i];
        end
    end

    assign rd_ext  = {{VAL_W{1'b0}}, rd_val};
    assign cnt_ext = {{COUNT_W{1'b0}}, count_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg    <= status;
            removed_reg   <= ctl.rem ? rd_ext[VAL_W-1:0] : '0;
            count_out_reg <= cnt_ext[COUNT_W-1:0];
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = status_reg;
    assign m_removed_value = removed_reg;
    assign m_entry_count   = count_out_reg;

endmodule

@@ rtl/ple_checker.sv @@
// Port-level checks for the positional list engine, bound to the top.
module ple_checker #(
    parameter int DEPTH = ple_pkg::DEPTH_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [ple_pkg::STAT_W-1:0]    m_status,
    input  logic [ple_pkg::VAL_W-1:0]     m_removed_value,
    input  logic [ple_pkg::COUNT_W-1:0]   m_entry_count
);
    import ple_pkg::*;

    localparam logic [COUNT_W-1:0] DEPTH_C = COUNT_W'(DEPTH);

    // an accepted word always yields a result next cycle
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("accepted word produced no result");

    // stalled result must hold
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status)
            && $stable(m_removed_value) && $stable(m_entry_count))
        else $error("stalled result changed");

    // errors never return data
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_OK |-> m_removed_value == '0)
        else $error("error result carries a removed value");

    a_empty_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_EMPTY |-> m_entry_count == '0)
        else $error("empty status with nonzero count");

    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_FULL |-> m_entry_count == DEPTH_C)
        else $error("full status with count below depth");

endmodule

bind positional_list_engine ple_checker #(
    .DEPTH (DEPTH)
) u_ple_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_status        (m_status),
    .m_removed_value (m_removed_value),
    .m_entry_count   (m_entry_count)
);

@@ sim/tb_positional_list_engine.sv @@
// Self-checking testbench for the positional list engine.
module tb_positional_list_engine;
    timeunit 1ns;
    timeprecision 1ps;

    import ple_pkg::*;

    localparam int LIST_DEPTH = DEPTH_DEFAULT;

    // op codes the block does not decode
    localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;

    typedef struct {
        logic [OP_W-1:0]  op;
        logic [POS_W-1:0] position;
        logic [VAL_W-1:0] value;
    } list_cmd_t;

    typedef struct {
        status_t            status;
        logic [VAL_W-1:0]   removed;
        logic [COUNT_W-1:0] count;
    } list_reply_t;

    logic                 aclk       = 1'b0;
    logic                 aresetn    = 1'b0;
    logic                 s_valid    = 1'b0;
    logic                 s_ready;
    logic [OP_W-1:0]      s_op       = '0;
    logic [POS_W-1:0]     s_position = '0;
    logic [VAL_W-1:0]     s_value    = '0;
    logic                 m_valid;
    logic                 m_ready    = 1'b0;
    logic [STAT_W-1:0]    m_status;
    logic [VAL_W-1:0]     m_removed_value;
    logic [COUNT_W-1:0]   m_entry_count;

    list_cmd_t   cmd_q[$];
    list_reply_t reply_q[$];
    int          unaccepted = 0;
    int          err_cnt    = 0;
    int          gen_fill   = 0;
    int          src_gap    = 0;
    int          sink_stall = 0;
    logic        calm       = 1'b0;

    // shadow copy of the list
    logic [VAL_W-1:0] shadow_list [LIST_DEPTH];
    int               shadow_count = 0;

    positional_list_engine u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_position      (s_position),
        .s_value         (s_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_removed_value (m_removed_value),
        .m_entry_count   (m_entry_count)
    );

    always #5 aclk = ~aclk;

    // Applies one operation to the shadow list and returns the reply it gives.
    function automatic list_reply_t list_op_reply(list_cmd_t c);
        list_reply_t r;
        int          at;
        r.status  = ST_OK;
        r.removed = '0;
        case (c.op)
            OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
                if (c.op == OP_INS_FRONT)
                    at = 0;
                else if (c.op == OP_INS_BACK)
                    at = shadow_count;
                else
                    at = c.position;
                // position check wins over full
                if (at > shadow_count) begin
                    r.status = ST_RANGE;
                end else if (shadow_count >= LIST_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    for (int i = shadow_count; i > at; i--)
                        shadow_list[i] = shadow_list[i-1];
                    shadow_list[at] = c.value;
                    shadow_count++;
                end
            end
            OP_REM_FRONT, OP_REM_BACK, OP_REM_AT: begin
                if (c.op == OP_REM_FRONT)
                    at = 0;
                else if (c.op == OP_REM_BACK)
                    at = (shadow_count == 0) ? 0 : shadow_count - 1;
                else
                    at = c.position;
                // empty wins over position check
                if (shadow_count == 0) begin
                    r.status = ST_EMPTY;
                end else if (at >= shadow_count) begin
                    r.status = ST_RANGE;
                end else begin
                    r.removed = shadow_list[at];
                    for (int i = at; i + 1 < shadow_count; i++)
                        shadow_list[i] = shadow_list[i+1];
                    shadow_count--;
                end
            end
            default: ;
        endcase
        r.count = shadow_count[COUNT_W-1:0];
        return r;
    endfunction

    // Entry count after c, tracked at generation time to aim positions.
    function automatic int fill_after(int fill, list_cmd_t c);
        case (c.op)
            OP_INS_FRONT, OP_INS_BACK: return (fill < LIST_DEPTH) ? fill + 1 : fill;
            OP_INS_AT:    return (c.position <= fill && fill < LIST_DEPTH) ? fill + 1 : fill;
            OP_REM_FRONT, OP_REM_BACK: return (fill > 0) ? fill - 1 : fill;
            OP_REM_AT:    return (c.position < fill) ? fill - 1 : fill;
            default:      return fill;
        endcase
    endfunction

    task automatic push_cmd(list_cmd_t c);
        cmd_q.push_back(c);
        unaccepted++;
        gen_fill = fill_after(gen_fill, c);
    endtask

    // n random words; ins_pct sets the insert/remove mix so the list drifts
    // toward full or empty.
    task automatic push_random(int n, int ins_pct);
        list_cmd_t c;
        logic      ins;
        repeat (n) begin
            ins = ($urandom_range(0, 99) < ins_pct);
            c.value = VAL_W'($urandom_range(0, 16'hFFFF));
            if ($urandom_range(0, 15) == 0)
                c.value = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            if ($urandom_range(0, 32) == 0) begin
                c.op = $urandom_range(0, 1) ? OP_SPARE7 : OP_SPARE6;
            end else if (ins) begin
                case ($urandom_range(0, 2))
                    0:       c.op = OP_INS_FRONT;
                    1:       c.op = OP_INS_BACK;
                    default: c.op = OP_INS_AT;
                endcase
            end else begin
                case ($urandom_range(0, 2))
                    0:       c.op = OP_REM_FRONT;
                    1:       c.op = OP_REM_BACK;
                    default: c.op = OP_REM_AT;
                endcase
            end
            if ($urandom_range(0, 4) == 0)
                c.position = POS_W'($urandom_range(0, 127));
            else if (ins)
                c.position = POS_W'($urandom_range(0, gen_fill));
            else
                c.position = (gen_fill == 0) ? '0 : POS_W'($urandom_range(0, gen_fill - 1));
            push_cmd(c);
        end
    endtask

    task automatic wait_drained();
        while (unaccepted != 0 || reply_q.size() != 0)
            @(posedge aclk);
    endtask

    // driver
    always @(posedge aclk) begin
        list_cmd_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                nxt.op       = s_op;
                nxt.position = s_position;
                nxt.value    = s_value;
                reply_q.push_back(list_op_reply(nxt));
                unaccepted--;
            end
            if (s_valid && !s_ready) begin
                // hold word until taken
            end else if (src_gap > 0) begin
                src_gap--;
                s_valid <= 1'b0;
            end else if (cmd_q.size() == 0) begin
                s_valid <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                src_gap = $urandom_range(1, 12) - 1;
                s_valid <= 1'b0;
            end else begin
                nxt = cmd_q.pop_front();
                s_valid    <= 1'b1;
                s_op       <= nxt.op;
                s_position <= nxt.position;
                s_value    <= nxt.value;
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        list_reply_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (reply_q.size() == 0) begin
                    $error("result word with nothing expected");
                    err_cnt++;
                end else begin
                    want = reply_q.pop_front();
                    if (m_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_status);
                        err_cnt++;
                    end
                    if (m_removed_value !== want.removed) begin
                        $error("removed_value: expected %0h, got %0h",
                               want.removed, m_removed_value);
                        err_cnt++;
                    end
                    if (m_entry_count !== want.count) begin
                        $error("entry_count: expected %0d, got %0d",
                               want.count, m_entry_count);
                        err_cnt++;
                    end
                end
            end
            if (sink_stall > 0) begin
                sink_stall--;
                m_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                sink_stall = $urandom_range(1, 12) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        int done_rand;
        int blk;
        int pct;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // empty list: every removal reports empty, even at a bad position
        push_cmd('{OP_REM_FRONT, 7'd0,   16'h1234});
        push_cmd('{OP_REM_BACK,  7'd0,   16'h0000});
        push_cmd('{OP_REM_AT,    7'd0,   16'hFFFF});
        push_cmd('{OP_REM_AT,    7'd127, 16'h0000});
        // insert past the end, then in-range inserts, unused op codes and removals
        push_cmd('{OP_INS_AT,    7'd1,   16'hDEAD});
        push_cmd('{OP_INS_AT,    7'd127, 16'hFFFF});
        push_cmd('{OP_INS_FRONT, 7'd127, 16'h0000});
        push_cmd('{OP_INS_BACK,  7'd0,   16'hFFFF});
        push_cmd('{OP_INS_AT,    7'd1,   16'hA5A5});
        push_cmd('{OP_INS_AT,    7'd3,   16'h5A5A});
        push_cmd('{OP_INS_FRONT, 7'd64,  16'h8001});
        push_cmd('{OP_SPARE6,    7'd2,   16'hFFFF});
        push_cmd('{OP_SPARE7,    7'd127, 16'h7FFE});
        push_cmd('{OP_REM_AT,    7'd5,   16'h0000});
        push_cmd('{OP_REM_AT,    7'd64,  16'h0000});
        push_cmd('{OP_REM_AT,    7'd2,   16'hFFFF});
        push_cmd('{OP_REM_FRONT, 7'd127, 16'h0000});
        push_cmd('{OP_REM_BACK,  7'd127, 16'h0000});
        push_cmd('{OP_INS_AT,    7'd0,   16'h7FFE});
        push_cmd('{OP_REM_AT,    7'd0,   16'h0000});
        push_cmd('{OP_REM_BACK,  7'd0,   16'h0000});
        push_cmd('{OP_REM_BACK,  7'd0,   16'h0000});

        // sender holds off until every reply is back
        wait_drained();

        // fill run hits the full list
        push_random(90, 100);
        done_rand = 90;
        while (done_rand < 1650) begin
            blk = $urandom_range(30, 120);
            case ($urandom_range(0, 2))
                0:       pct = 90;
                1:       pct = 50;
                default: pct = 10;
            endcase
            push_random(blk, pct);
            done_rand += blk;
        end

        wait_drained();
        calm = 1'b1;
        push_random(250, 55);
        wait_drained();
        repeat (4) @(posedge aclk);

        if (err_cnt == 0)
            $display("** positional_list_engine: PASSED **");
        else
            $display("** positional_list_engine: FAILED **");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("** positional_list_engine: FAILED **");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/ple_pkg.sv
rtl/ple_cell.sv
rtl/positional_list_engine.sv
rtl/ple_checker.sv
sim/tb_positional_list_engine.sv
